FILE: rtl/core/tlpq_pkg.sv
// ----------------------------------------------------------------------------
// tlpq_pkg: shared types and constants for the two-level priority queue
// Field widths, command and status codes, and the FIFO control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int ITEM_W   = 32;   // item_data and out_data port width
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic CLASS_HIGH = 1'b0;
	localparam logic CLASS_LOW  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/tlpq_if.sv
// ----------------------------------------------------------------------------
// tlpq_if: channel interfaces of the two-level priority queue
// Request, response and capacity write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpq_req_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic                      item_class;
	logic [tlpq_pkg::ITEM_W-1:0] item_data;

	modport source (output valid, cmd, item_class, item_data, input ready);
	modport sink   (input valid, cmd, item_class, item_data, output ready);
endinterface

interface tlpq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tlpq_pkg::STATUS_W-1:0] status;
	logic                        served_class;
	logic [tlpq_pkg::ITEM_W-1:0]   out_data;

	modport source (output valid, status, served_class, out_data, input ready);
	modport sink   (input valid, status, served_class, out_data, output ready);
endinterface

interface tlpq_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [tlpq_pkg::CAP_W-1:0] capacity;

	modport source (output valid, capacity, input ready);
	modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/two_level_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// two_level_priority_queue_unit: high/low priority FIFO pair
// Enqueues into the named class, dequeues high before low.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per handshake: cmd (enqueue/dequeue), item_class,
//          item_data. Enqueue stores the word unless that FIFO holds the
//          configured capacity (status full, word dropped).
//   rsp  : exactly one response per request, in order: status, served_class,
//          out_data (zero unless a word was dequeued).
//   cfg  : capacity write, always ready; write only while the block is idle.
//          Zero acts as 1, values above DEPTH act as DEPTH.
// Timing:
//   A request is registered in the input stage at acceptance and processed
//   once the result register is free or being emptied; its response is registered.
//   One request per cycle sustained while rsp.ready is high; the FIFO state
//   is updated by the single processing stage, so back-to-back requests see
//   each other's effects. A stalled receiver holds the response; one more
//   request is held in the input stage, then req.ready drops.
// Reset: both FIFOs empty, heads at zero, capacity 16. Store contents are
//   not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_priority_queue_unit #(
	parameter int DEPTH      = tlpq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = tlpq_pkg::DATA_WIDTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	tlpq_req_if.sink    req,
	tlpq_rsp_if.source  rsp,
	tlpq_cfg_if.sink    cfg
);
	import tlpq_pkg::*;

	localparam int SW    = (DATA_WIDTH < ITEM_W) ? DATA_WIDTH : ITEM_W;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0]    cap_q;
	logic [CMP_W-1:0]    cap_ext;
	logic [CMP_W-1:0]    eff_wide;
	logic [CW-1:0]       eff_cap;

	logic                vld_s1;
	logic                cmd_s1;
	logic                cls_s1;
	logic [SW-1:0]       data_s1;

	logic                vld_s2;
	logic [STATUS_W-1:0] status_s2;
	logic                served_s2;
	logic                has_data_s2;

	logic                advance;
	logic                enq;
	logic                tgt_full;
	logic                serve_low;
	logic [STATUS_W-1:0] status_nxt;

	fifo_ctrl_t          hi_ctrl, lo_ctrl;
	fifo_stat_t          hi_stat, lo_stat;
	logic [SW-1:0]       hi_rdata, lo_rdata;
	logic [SW-1:0]       sel_rdata;

	// capacity register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.capacity;
		end
	end

	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_ext == '0) begin
			eff_wide = CMP_W'(1);
		end else if (cap_ext > CMP_W'(DEPTH)) begin
			eff_wide = CMP_W'(DEPTH);
		end else begin
			eff_wide = cap_ext;
		end
		eff_cap = CW'(eff_wide);
	end

	// input stage
	assign advance   = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1  <= req.cmd;
			cls_s1  <= req.item_class;
			data_s1 <= req.item_data[SW-1:0];
		end
	end

	// processing
	always_comb begin
		enq       = (cmd_s1 == CMD_ENQ);
		tgt_full  = (cls_s1 == CLASS_HIGH) ? hi_stat.full : lo_stat.full;
		serve_low = hi_stat.empty && !lo_stat.empty;

		hi_ctrl.push = advance && enq && (cls_s1 == CLASS_HIGH) && !hi_stat.full;
		lo_ctrl.push = advance && enq && (cls_s1 == CLASS_LOW) && !lo_stat.full;
		hi_ctrl.pop  = advance && !enq && !hi_stat.empty;
		lo_ctrl.pop  = advance && !enq && serve_low;

		if (enq) begin
			status_nxt = tgt_full ? STATUS_FULL : STATUS_OK;
		end else if (hi_stat.empty && lo_stat.empty) begin
			status_nxt = STATUS_EMPTY;
		end else begin
			status_nxt = STATUS_OK;
		end
	end

	tlpq_fifo #(.DEPTH(DEPTH), .SW(SW), .CW(CW)) u_hi_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (hi_ctrl),
		.wdata   (data_s1),
		.eff_cap (eff_cap),
		.stat    (hi_stat),
		.rdata   (hi_rdata)
	);

	tlpq_fifo #(.DEPTH(DEPTH), .SW(SW), .CW(CW)) u_lo_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (lo_ctrl),
		.wdata   (data_s1),
		.eff_cap (eff_cap),
		.stat    (lo_stat),
		.rdata   (lo_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (rsp.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2   <= status_nxt;
			served_s2   <= (!enq && serve_low) ? CLASS_LOW : CLASS_HIGH;
			has_data_s2 <= !enq && !(hi_stat.empty && lo_stat.empty);
		end
	end

	// read data registers only change on a pop, so a stalled response holds
	assign sel_rdata        = (served_s2 == CLASS_LOW) ? lo_rdata : hi_rdata;
	assign rsp.valid        = vld_s2;
	assign rsp.status       = status_s2;
	assign rsp.served_class = served_s2;
	assign rsp.out_data     = has_data_s2 ? ITEM_W'(sel_rdata) : '0;

	a_one_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(hi_ctrl.pop && lo_ctrl.pop))
		else $error("both FIFOs popped");

	a_low_after_high: assert property (@(posedge clk) disable iff (!arst_n)
		lo_ctrl.pop |-> hi_stat.empty)
		else $error("low served while high holds words");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STATUS_OK) |->
			(rsp.out_data == '0 && rsp.served_class == CLASS_HIGH))
		else $error("non-ok response carries data");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> $stable(rsp.out_data))
		else $error("stalled response data changed");

endmodule

`default_nettype wire

FILE: rtl/core/tlpq_fifo.sv
// ----------------------------------------------------------------------------
// tlpq_fifo: one circular FIFO of the priority queue
// Head pointer, fill count and word store; registered read on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_fifo #(
	parameter int DEPTH = tlpq_pkg::DEPTH_DEF,
	parameter int SW    = tlpq_pkg::DATA_WIDTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  tlpq_pkg::fifo_ctrl_t     ctrl,
	input  wire  [SW-1:0]            wdata,
	input  wire  [CW-1:0]            eff_cap,
	output tlpq_pkg::fifo_stat_t     stat,
	output logic [SW-1:0]            rdata
);
	import tlpq_pkg::*;

	localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUMW = ((IW > CW) ? IW : CW) + 1;

	logic [SW-1:0]   mem [DEPTH];
	logic [IW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [SW-1:0]   rdata_q;
	logic [SUMW-1:0] tail_sum;
	logic [IW-1:0]   tail;
	logic [IW-1:0]   head_inc;

	assign stat.full  = (count_q >= eff_cap);
	assign stat.empty = (count_q == '0);
	assign rdata      = rdata_q;

	// tail = (head + count) mod DEPTH; the sum stays below twice DEPTH
	always_comb begin
		tail_sum = SUMW'(head_q) + SUMW'(count_q);
		if (tail_sum >= SUMW'(DEPTH)) begin
			tail = IW'(tail_sum - SUMW'(DEPTH));
		end else begin
			tail = IW'(tail_sum);
		end
		head_inc = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + CW'(1);
		end else if (ctrl.pop) begin
			head_q  <= head_inc;
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			rdata_q <= mem[head_q];
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> !stat.full)
		else $error("push into full FIFO");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> !stat.empty)
		else $error("pop from empty FIFO");

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.push && ctrl.pop))
		else $error("push and pop in one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("FIFO count above depth");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not lower count");

endmodule

`default_nettype wire
